// ===== design/lcm_pkg.sv =====
`default_nettype none

package lcm_pkg;

  // one line y = a*x + b
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
  } lcm_line_t;

  localparam logic signed [31:0] LC_INF     = 32'sd1061109567;
  localparam int                 MAX_LEVELS = 32;
  localparam int                 LVW        = $clog2(MAX_LEVELS);
  localparam int                 QLW        = $clog2(MAX_LEVELS + 1);

  localparam lcm_line_t DEFAULT_LINE = '{a: 32'sd0, b: -LC_INF};

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_UNDO   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ===== design/lcm_ram.sv =====
`default_nettype none

module lcm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/lcm_node_mem.sv =====
`default_nettype none

module lcm_node_mem
  import lcm_pkg::*;
#(
  parameter int NODES = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     re_i,
  input  wire logic [$clog2(NODES)-1:0] raddr_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(NODES)-1:0] waddr_i,
  input  wire logic [$clog2(NODES)-1:0] wlo_i,
  input  wire logic [$clog2(NODES)-1:0] whi_i,
  input  wire lcm_line_t                wline_i,
  output logic      [$clog2(NODES)-1:0] rlo_o,
  output logic      [$clog2(NODES)-1:0] rhi_o,
  output lcm_line_t                     rline_o
);

  localparam int IW = $clog2(NODES);
  localparam int NW = 2 * IW + 64;

  logic [NW-1:0] mem [NODES];
  logic [NW-1:0] rdata_q;
  logic          root_ok_q;
  logic          rd_root_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wlo_i, whi_i, wline_i};
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // root reads as empty until it is first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_ok_q <= 1'b0;
      rd_root_q <= 1'b0;
    end else begin
      if (we_i && (waddr_i == '0)) begin
        root_ok_q <= 1'b1;
      end
      if (re_i) begin
        rd_root_q <= (raddr_i == '0);
      end
    end
  end

  always_comb begin
    if (rd_root_q && !root_ok_q) begin
      rlo_o   = '0;
      rhi_o   = '0;
      rline_o = DEFAULT_LINE;
    end else begin
      rlo_o   = rdata_q[NW-1 -: IW];
      rhi_o   = rdata_q[NW-IW-1 -: IW];
      rline_o = lcm_line_t'(rdata_q[63:0]);
    end
  end

endmodule

`default_nettype wire

// ===== design/lcm_eval.sv =====
`default_nettype none

module lcm_eval
  import lcm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire lcm_line_t          ln0_i,
  input  wire lcm_line_t          ln1_i,
  input  wire logic signed [31:0] x_i,
  output logic signed      [63:0] v0_o,
  output logic signed      [63:0] v1_o
);

  // two lanes, product then sum: the product and b are registered, then the sum is registered
  logic signed [63:0] prod0_q, prod1_q;
  logic signed [31:0] b0_q, b1_q;

  always_ff @(posedge clk_i) begin
    prod0_q <= 64'(ln0_i.a) * 64'(x_i);
    prod1_q <= 64'(ln1_i.a) * 64'(x_i);
    b0_q    <= ln0_i.b;
    b1_q    <= ln1_i.b;
    v0_o    <= prod0_q + 64'(b0_q);
    v1_o    <= prod1_q + 64'(b1_q);
  end

endmodule

`default_nettype wire

// ===== design/li_chao_max_line_with_rollback_unit.sv =====
`default_nettype none

// Li Chao tree for the maximum of lines over x in [-LC_INF, LC_INF], with undo
// of the last insert. Pulse start while busy is low to hand over one beat;
// exactly one result beat follows on done_o for a single cycle, and the
// receiver cannot stall it. The tree sits in one node memory (children and
// line per entry) with a registered read; each insert logs every node it
// visits into the undo log, and a mark memory keeps the log top and node
// count per insert. Per tree level an insert reads the node, loads and logs
// it and runs three pipelined line evaluations at l, r and mid, over up to 32
// levels, then finishes, first clearing a leaf allocated on the last level;
// a query reads, loads and evaluates each node on its path; an undo reads
// each logged node from the log and writes it back. A rejected insert, an
// empty undo or an unused code goes straight to finishing.
module li_chao_max_line_with_rollback_unit
  import lcm_pkg::*;
#(
  parameter int NODES        = 4096,
  parameter int UNDO_ENTRIES = 16384,
  parameter int VERSIONS     = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic        [1:0]  req_type_i,
  input  wire logic signed [31:0] slope_i,
  input  wire logic signed [31:0] intercept_i,
  input  wire logic signed [30:0] query_x_i,
  output logic                    done_o,
  output logic signed      [62:0] value_o,
  output logic                    tree_empty_o,
  output logic             [1:0]  status_o
);

  localparam int IW  = $clog2(NODES);
  localparam int NCW = $clog2(NODES + 1);
  localparam int UAW = $clog2(UNDO_ENTRIES);
  localparam int UW  = $clog2(UNDO_ENTRIES + 1);
  localparam int VAW = $clog2(VERSIONS);
  localparam int VW  = $clog2(VERSIONS + 1);
  localparam int LW  = 3 * IW + 64;
  localparam int MW  = UW + NCW;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_IRD   = 5'd1;
  localparam logic [4:0] S_ILD   = 5'd2;
  localparam logic [4:0] S_IE0   = 5'd3;
  localparam logic [4:0] S_IE1   = 5'd4;
  localparam logic [4:0] S_IE2   = 5'd5;
  localparam logic [4:0] S_IE3   = 5'd6;
  localparam logic [4:0] S_IE4   = 5'd7;
  localparam logic [4:0] S_IINIT = 5'd8;
  localparam logic [4:0] S_QRD   = 5'd9;
  localparam logic [4:0] S_QLD   = 5'd10;
  localparam logic [4:0] S_QE0   = 5'd11;
  localparam logic [4:0] S_QE1   = 5'd12;
  localparam logic [4:0] S_QE2   = 5'd13;
  localparam logic [4:0] S_UMK   = 5'd14;
  localparam logic [4:0] S_URD   = 5'd15;
  localparam logic [4:0] S_UWR   = 5'd16;
  localparam logic [4:0] S_FIN   = 5'd17;

  logic [4:0]         state_q;
  logic [VW-1:0]      vc_q;
  logic [NCW-1:0]     nodes_used_q;
  logic [UW-1:0]      undo_top_q;
  logic [UW-1:0]      start_top_q;
  logic [NCW-1:0]     mark_nodes_q;
  logic [IW-1:0]      idx_q, lo_q, hi_q;
  logic               fresh_q, swap_q;
  logic [LVW-1:0]     lev_q;
  logic [QLW-1:0]     qlev_q;
  logic signed [31:0] l_q, r_q, qx_q;
  lcm_line_t          n_q, carry_q;
  logic signed [63:0] best_q;
  logic signed [62:0] val_q;
  logic [1:0]         st_q;
  logic               empty_q, done_q;

  // memory ports
  logic          node_re, node_we;
  logic [IW-1:0] node_waddr, node_wlo, node_whi, node_rlo, node_rhi;
  lcm_line_t     node_wline, node_rline;
  logic          log_we, log_re;
  logic [UAW-1:0] log_waddr, log_raddr;
  logic [LW-1:0] log_wdata, log_rdata;
  logic          mark_we, mark_re;
  logic [VAW-1:0] mark_addr;
  logic [MW-1:0] mark_rdata;

  // evaluator
  logic signed [31:0] ev_x;
  logic signed [63:0] v_n, v_c, v_lo, v_hi;

  logic               accept;
  logic               full;
  logic signed [32:0] lr_sum;
  logic signed [31:0] mid;
  logic               lo_wins;
  lcm_line_t          low_ln, high_ln;
  logic [IW-1:0]      alloc_idx;
  logic [IW-1:0]      cur_lo, cur_hi;
  lcm_line_t          cur_line;
  logic signed [63:0] q_best;
  logic               q_left;
  logic [IW-1:0]      q_next;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  assign full = ((32'(nodes_used_q) + 32'(MAX_LEVELS)) > 32'(NODES)) ||
                ((32'(undo_top_q) + 32'(MAX_LEVELS)) > 32'(UNDO_ENTRIES)) ||
                (32'(vc_q) >= 32'(VERSIONS));

  // floor midpoint: drop the low bit of the 33-bit sum
  assign lr_sum = 33'(l_q) + 33'(r_q);
  assign mid    = lr_sum[32:1];

  assign low_ln  = swap_q ? carry_q : n_q;
  assign high_ln = swap_q ? n_q : carry_q;
  assign v_lo    = swap_q ? v_c : v_n;
  assign v_hi    = swap_q ? v_n : v_c;
  assign lo_wins = (v_lo <= v_hi);   // high line stays on top at r / mid

  assign alloc_idx = nodes_used_q[IW-1:0];

  assign cur_lo   = fresh_q ? '0 : node_rlo;
  assign cur_hi   = fresh_q ? '0 : node_rhi;
  assign cur_line = fresh_q ? DEFAULT_LINE : node_rline;

  assign q_best = ((qlev_q == '0) || (v_n > best_q)) ? v_n : best_q;
  assign q_left = (qx_q <= mid);
  assign q_next = q_left ? lo_q : hi_q;

  always_comb begin
    unique case (state_q)
      S_IE0:   ev_x = l_q;
      S_IE1:   ev_x = r_q;
      S_IE2:   ev_x = mid;
      S_QE0:   ev_x = qx_q;
      default: ev_x = l_q;
    endcase
  end

  always_comb begin
    node_re    = (state_q == S_IRD) || (state_q == S_QRD);
    node_we    = 1'b0;
    node_waddr = idx_q;
    node_wlo   = lo_q;
    node_whi   = hi_q;
    node_wline = high_ln;
    unique case (state_q)
      S_IE3: begin
        node_we = lo_wins;
      end
      S_IE4: begin
        node_we = 1'b1;
        if (lo_wins) begin
          node_wline = high_ln;
          if (hi_q == '0) begin
            node_whi = alloc_idx;
          end
        end else begin
          node_wline = low_ln;
          if (lo_q == '0) begin
            node_wlo = alloc_idx;
          end
        end
      end
      S_IINIT: begin
        node_we    = 1'b1;
        node_wlo   = '0;
        node_whi   = '0;
        node_wline = DEFAULT_LINE;
      end
      S_UWR: begin
        node_we    = 1'b1;
        node_waddr = log_rdata[LW-1 -: IW];
        node_wlo   = log_rdata[LW-IW-1 -: IW];
        node_whi   = log_rdata[LW-2*IW-1 -: IW];
        node_wline = lcm_line_t'(log_rdata[63:0]);
      end
      default: ;
    endcase
  end

  assign log_we    = (state_q == S_ILD);
  assign log_waddr = undo_top_q[UAW-1:0];
  assign log_wdata = {idx_q, cur_lo, cur_hi, cur_line};
  assign log_re    = (state_q == S_URD) && (undo_top_q > start_top_q);
  assign log_raddr = UAW'(undo_top_q - UW'(1));

  assign mark_we   = accept && (req_type_i == REQ_INSERT) && !full;
  assign mark_re   = accept && (req_type_i == REQ_UNDO) && (vc_q != '0);
  assign mark_addr = mark_we ? vc_q[VAW-1:0] : VAW'(vc_q - VW'(1));

  lcm_node_mem #(.NODES(NODES)) u_node_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (node_re),
    .raddr_i (idx_q),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wlo_i   (node_wlo),
    .whi_i   (node_whi),
    .wline_i (node_wline),
    .rlo_o   (node_rlo),
    .rhi_o   (node_rhi),
    .rline_o (node_rline)
  );

  lcm_ram #(.DEPTH(UNDO_ENTRIES), .WIDTH(LW)) u_log_ram (
    .clk_i   (clk_i),
    .we_i    (log_we),
    .waddr_i (log_waddr),
    .wdata_i (log_wdata),
    .re_i    (log_re),
    .raddr_i (log_raddr),
    .rdata_o (log_rdata)
  );

  lcm_ram #(.DEPTH(VERSIONS), .WIDTH(MW)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_addr),
    .wdata_i ({undo_top_q, nodes_used_q}),
    .re_i    (mark_re),
    .raddr_i (mark_addr),
    .rdata_o (mark_rdata)
  );

  lcm_eval u_eval (
    .clk_i (clk_i),
    .ln0_i (n_q),
    .ln1_i (carry_q),
    .x_i   (ev_x),
    .v0_o  (v_n),
    .v1_o  (v_c)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      vc_q         <= '0;
      nodes_used_q <= NCW'(1);
      undo_top_q   <= '0;
      done_q       <= 1'b0;
      empty_q      <= 1'b1;
      val_q        <= '0;
      st_q         <= ST_OK;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            val_q <= '0;
            st_q  <= ST_OK;
            case (req_type_i)
              REQ_INSERT: begin
                if (full) begin
                  st_q    <= ST_FULL;
                  state_q <= S_FIN;
                end else begin
                  vc_q    <= vc_q + VW'(1);
                  state_q <= S_IRD;
                end
              end
              REQ_QUERY: state_q <= S_QRD;
              REQ_UNDO: begin
                if (vc_q == '0) begin
                  st_q    <= ST_EMPTY;
                  state_q <= S_FIN;
                end else begin
                  vc_q    <= vc_q - VW'(1);
                  state_q <= S_UMK;
                end
              end
              default: state_q <= S_FIN;
            endcase
          end
        end
        S_IRD: state_q <= S_ILD;
        S_ILD: begin
          undo_top_q <= undo_top_q + UW'(1);
          state_q    <= S_IE0;
        end
        S_IE0: state_q <= S_IE1;
        S_IE1: state_q <= S_IE2;
        S_IE2: state_q <= S_IE3;
        S_IE3: state_q <= lo_wins ? S_FIN : S_IE4;
        S_IE4: begin
          if ((lo_wins && (hi_q == '0)) || (!lo_wins && (lo_q == '0))) begin
            nodes_used_q <= nodes_used_q + NCW'(1);
            // a leaf made on the last level is never visited: clear it in S_IINIT
            state_q <= (lev_q == LVW'(MAX_LEVELS - 1)) ? S_IINIT : S_IRD;
          end else begin
            state_q <= (lev_q == LVW'(MAX_LEVELS - 1)) ? S_FIN : S_IRD;
          end
        end
        S_IINIT: state_q <= S_FIN;
        S_QRD:   state_q <= S_QLD;
        S_QLD:   state_q <= S_QE0;
        S_QE0:   state_q <= S_QE1;
        S_QE1:   state_q <= S_QE2;
        S_QE2: begin
          if ((q_next == '0) || (qlev_q == QLW'(MAX_LEVELS))) begin
            val_q   <= q_best[62:0];
            state_q <= S_FIN;
          end else begin
            state_q <= S_QRD;
          end
        end
        S_UMK: state_q <= S_URD;
        S_URD: begin
          if (undo_top_q > start_top_q) begin
            undo_top_q <= undo_top_q - UW'(1);
            state_q    <= S_UWR;
          end else begin
            if ((mark_nodes_q == '0) || (32'(mark_nodes_q) > 32'(NODES))) begin
              nodes_used_q <= NCW'(1);
            end else begin
              nodes_used_q <= mark_nodes_q;
            end
            state_q <= S_FIN;
          end
        end
        S_UWR: state_q <= S_URD;
        S_FIN: begin
          done_q  <= 1'b1;
          empty_q <= (vc_q == '0);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        idx_q   <= '0;
        fresh_q <= 1'b0;
        lev_q   <= '0;
        qlev_q  <= '0;
        l_q     <= -LC_INF;
        r_q     <= LC_INF;
        qx_q    <= 32'(query_x_i);
        carry_q <= '{a: slope_i, b: intercept_i};
      end
      S_ILD, S_QLD: begin
        n_q  <= cur_line;
        lo_q <= cur_lo;
        hi_q <= cur_hi;
      end
      S_IE2: swap_q <= (v_n >= v_c);
      S_IE4: begin
        lev_q <= lev_q + LVW'(1);
        if (lo_wins) begin
          carry_q <= low_ln;
          l_q     <= mid + 32'sd1;
          idx_q   <= (hi_q == '0) ? alloc_idx : hi_q;
          fresh_q <= (hi_q == '0);
        end else begin
          carry_q <= high_ln;
          r_q     <= mid;
          idx_q   <= (lo_q == '0) ? alloc_idx : lo_q;
          fresh_q <= (lo_q == '0);
        end
      end
      S_QE2: begin
        best_q <= q_best;
        qlev_q <= qlev_q + QLW'(1);
        idx_q  <= q_next;
        if (q_left) begin
          r_q <= mid;
        end else begin
          l_q <= mid + 32'sd1;
        end
      end
      S_UMK: begin
        start_top_q  <= mark_rdata[MW-1 -: UW];
        mark_nodes_q <= mark_rdata[NCW-1:0];
      end
      default: ;
    endcase
  end

  assign done_o       = done_q;
  assign value_o      = val_q;
  assign tree_empty_o = empty_q;
  assign status_o     = st_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("beat taken but unit not busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (value_o == '0))
    else $error("rejected beat carries a value");

  a_nodes_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nodes_used_q != '0) else $error("node count lost the root");

endmodule

`default_nettype wire
